// ----- design/chacha20_keystream_xor_top_macros.svh -----
// ----------------------------------------------------------------------------
// chacha20 keystream xor assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CC20_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and register codes of the chacha20 block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

	localparam int ROUNDS = 20;
	localparam int RND_W  = $clog2(ROUNDS + 1);

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646E;
	localparam logic [31:0] SIGMA2 = 32'h7962_2D32;
	localparam logic [31:0] SIGMA3 = 32'h6B20_6574;

	// quarter-round word picks, nibbles d c b a; column set then diagonal set
	localparam logic [15:0] QR_SEL [8] = '{
		16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
		16'hFA50, 16'hCB61, 16'hD872, 16'hE943
	};

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE        = 3'd4;

	localparam logic [3:0] BYTES_PER_BEAT = 4'd8;

	typedef struct packed {
		logic   start;
		state_t init;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/cc20_qr.sv -----
// ----------------------------------------------------------------------------
// cc20_qr
// one chacha quarter-round lane, fully combinational
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cc20_qr (
	input  cc20_pkg::word_t a_in,
	input  cc20_pkg::word_t b_in,
	input  cc20_pkg::word_t c_in,
	input  cc20_pkg::word_t d_in,
	output cc20_pkg::word_t a_out,
	output cc20_pkg::word_t b_out,
	output cc20_pkg::word_t c_out,
	output cc20_pkg::word_t d_out
);

	cc20_pkg::word_t a1, b1, c1, d1, a2, b2, c2, d2;
	cc20_pkg::word_t t0, t1, t2, t3;

	always_comb begin
		a1 = a_in + b_in;
		t0 = d_in ^ a1;
		d1 = {t0[15:0], t0[31:16]};
		c1 = c_in + d1;
		t1 = b_in ^ c1;
		b1 = {t1[19:0], t1[31:20]};
		a2 = a1 + b1;
		t2 = d1 ^ a2;
		d2 = {t2[23:0], t2[31:24]};
		c2 = c1 + d2;
		t3 = b1 ^ c2;
		b2 = {t3[24:0], t3[31:25]};
	end

	assign a_out = a2;
	assign b_out = b2;
	assign c_out = c2;
	assign d_out = d2;

endmodule

`default_nettype wire

// ----- design/cc20_core.sv -----
// ----------------------------------------------------------------------------
// cc20_core
// block function: four quarter-round lanes, one round a cycle, then feed-forward add
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cc20_core (
	input  logic             clk,
	input  logic             arst_n,
	input  cc20_pkg::cmd_t   cmd,
	output cc20_pkg::sts_t   sts,
	output cc20_pkg::state_t block
);

	cc20_pkg::state_t x_q;
	cc20_pkg::state_t init_q;
	cc20_pkg::state_t x_rnd;
	cc20_pkg::state_t x_fin;
	logic [cc20_pkg::RND_W-1:0] rnd_q;
	logic busy_q;
	logic done_q;
	logic last_step;
	logic load;

	logic [15:0]     sel [4];
	cc20_pkg::word_t qa [4];
	cc20_pkg::word_t qb [4];
	cc20_pkg::word_t qc [4];
	cc20_pkg::word_t qd [4];

	assign last_step = (rnd_q == cc20_pkg::RND_W'(cc20_pkg::ROUNDS));
	assign load      = cmd.start && !busy_q;

	// lanes: column round on even steps, diagonal on odd
	for (genvar l = 0; l < 4; l++) begin : g_lane
		assign sel[l] = cc20_pkg::QR_SEL[{rnd_q[0], 2'(l)}];
		cc20_qr u_qr (
			.a_in  (x_q[sel[l][3:0]]),
			.b_in  (x_q[sel[l][7:4]]),
			.c_in  (x_q[sel[l][11:8]]),
			.d_in  (x_q[sel[l][15:12]]),
			.a_out (qa[l]),
			.b_out (qb[l]),
			.c_out (qc[l]),
			.d_out (qd[l])
		);
	end

	// merge: lanes touch disjoint words
	always_comb begin
		x_rnd = x_q;
		for (int l = 0; l < 4; l++) begin
			x_rnd[sel[l][3:0]]   = qa[l];
			x_rnd[sel[l][7:4]]   = qb[l];
			x_rnd[sel[l][11:8]]  = qc[l];
			x_rnd[sel[l][15:12]] = qd[l];
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			x_fin[i] = x_q[i] + init_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= cmd.init;
			init_q <= cmd.init;
		end else if (busy_q) begin
			x_q <= last_step ? x_fin : x_rnd;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign block    = x_q;

endmodule

`default_nettype wire

// ----- design/chacha20_keystream_xor_top.sv -----
// ----------------------------------------------------------------------------
// chacha20 keystream xor
// chacha20 stream cipher (64-bit nonce, 64-bit counter), 8 data bytes a beat
// ----------------------------------------------------------------------------
// usage
//   config: cfg_we writes cfg_data into register cfg_index (0..3 key words,
//   4 nonce); any valid write rewinds to block 0, word 0. write only when idle
//   input beat: in_valid with in_stall low takes data_in and byte_count
//   (values above 8 count as 8, zero gives an all-zero beat with count zero)
//   output beat: out_valid with out_stall low hands over data_out and
//   byte_count_out; unused high bytes are zero
// throughput and block wait
//   with a keystream word on hand and room at the output, a held beat is
//   finished into the output register and the next beat is taken in the same
//   cycle, so beats stream at one per cycle
//   the first beat of each 64-byte block waits for the block function: a
//   load, ROUNDS rounds (four quarter-round lanes each), the feed-forward
//   add and a step to mark the block ready
// reset and back-pressure
//   reset clears key, nonce, counter and position; no block is held
//   while out_stall is high the result stays put, one more beat is held in
//   the input register, and in_stall rises until the output drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chacha20_keystream_xor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [63:0]                    data_in,
	input  logic [3:0]                     byte_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [63:0]                    data_out,
	output logic [3:0]                     byte_count_out
);

	// configuration registers
	logic [63:0] key_low_q;
	logic [63:0] key_mid_low_q;
	logic [63:0] key_mid_high_q;
	logic [63:0] key_high_q;
	logic [63:0] nonce_q;
	logic        cfg_hit;

	// stream position
	logic [63:0] counter_q;
	logic [2:0]  pos_q;
	logic        ks_ready_q;

	// held input beat
	logic        item_valid_q;
	logic [63:0] item_data_q;
	logic [3:0]  item_cnt_q;
	logic [3:0]  cnt_sat;

	// output register
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [3:0]  out_cnt_q;

	// block function
	cc20_pkg::cmd_t   cmd;
	cc20_pkg::sts_t   sts;
	cc20_pkg::state_t block;

	logic        in_take;
	logic        fire;
	logic        out_room;
	logic        item_empty;
	logic [63:0] ks_word;
	logic [63:0] mask;

	assign cnt_sat    = (byte_count > cc20_pkg::BYTES_PER_BEAT) ?
	                    cc20_pkg::BYTES_PER_BEAT : byte_count;
	assign item_empty = (item_cnt_q == 4'd0);
	assign out_room   = !out_valid_q || !out_stall;
	// finish a held beat once empty or its keystream word exists and output has room
	assign fire       = item_valid_q && (item_empty || ks_ready_q) && out_room;
	assign in_stall   = item_valid_q && !fire;
	assign in_take    = in_valid && !in_stall;

	always_comb begin
		// kick the core for the first beat of a block
		cmd.start    = item_valid_q && !item_empty && !ks_ready_q && !sts.busy && !sts.done;
		cmd.init     = '0;
		cmd.init[0]  = cc20_pkg::SIGMA0;
		cmd.init[1]  = cc20_pkg::SIGMA1;
		cmd.init[2]  = cc20_pkg::SIGMA2;
		cmd.init[3]  = cc20_pkg::SIGMA3;
		cmd.init[4]  = key_low_q[31:0];
		cmd.init[5]  = key_low_q[63:32];
		cmd.init[6]  = key_mid_low_q[31:0];
		cmd.init[7]  = key_mid_low_q[63:32];
		cmd.init[8]  = key_mid_high_q[31:0];
		cmd.init[9]  = key_mid_high_q[63:32];
		cmd.init[10] = key_high_q[31:0];
		cmd.init[11] = key_high_q[63:32];
		cmd.init[12] = counter_q[31:0];
		cmd.init[13] = counter_q[63:32];
		cmd.init[14] = nonce_q[31:0];
		cmd.init[15] = nonce_q[63:32];
	end

	cc20_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.block  (block)
	);

	// keystream word for the current position, low word first
	assign ks_word = {block[{pos_q, 1'b1}], block[{pos_q, 1'b0}]};

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			mask[8*j +: 8] = {8{4'(j) < item_cnt_q}};
		end
	end

	always_comb begin
		cfg_hit = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				cc20_pkg::REG_KEY_LOW,
				cc20_pkg::REG_KEY_MID_LOW,
				cc20_pkg::REG_KEY_MID_HIGH,
				cc20_pkg::REG_KEY_HIGH,
				cc20_pkg::REG_NONCE: cfg_hit = 1'b1;
				default:             cfg_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q      <= '0;
			key_mid_low_q  <= '0;
			key_mid_high_q <= '0;
			key_high_q     <= '0;
			nonce_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cc20_pkg::REG_KEY_LOW:      key_low_q      <= cfg_data;
				cc20_pkg::REG_KEY_MID_LOW:  key_mid_low_q  <= cfg_data;
				cc20_pkg::REG_KEY_MID_HIGH: key_mid_high_q <= cfg_data;
				cc20_pkg::REG_KEY_HIGH:     key_high_q     <= cfg_data;
				cc20_pkg::REG_NONCE:        nonce_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter, position and block-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q  <= '0;
			pos_q      <= '0;
			ks_ready_q <= 1'b0;
		end else if (cfg_hit) begin
			counter_q  <= '0;
			pos_q      <= '0;
			ks_ready_q <= 1'b0;
		end else begin
			if (sts.done) begin
				ks_ready_q <= 1'b1;
				counter_q  <= counter_q + 64'd1;
			end
			if (fire && !item_empty) begin
				pos_q <= pos_q + 3'd1;
				// last word of the block used up
				if (pos_q == 3'd7) begin
					ks_ready_q <= 1'b0;
				end
			end
		end
	end

	// input holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (in_take) begin
			item_valid_q <= 1'b1;
		end else if (fire) begin
			item_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_data_q <= data_in;
			item_cnt_q  <= cnt_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= item_empty ? 64'd0 : ((item_data_q ^ ks_word) & mask);
			out_cnt_q  <= item_cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_out       = out_data_q;
	assign byte_count_out = out_cnt_q;

endmodule

`default_nettype wire

// ----- design/cc20_checker.sv -----
// ----------------------------------------------------------------------------
// cc20_checker
// port-level checks on the chacha20 keystream xor block, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chacha20_keystream_xor_top_macros.svh"

module cc20_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [3:0]  byte_count,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] data_out,
	input logic [3:0]  byte_count_out
);

	// a stalled result beat stays and keeps its payload
	`CC20_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_out) && $stable(byte_count_out), "result beat changed while stalled")

	// count never above eight, bytes past the count are zero
	`CC20_ASSERT_NOW(a_out_bytes, out_valid, (byte_count_out <= 4'd8) && ((data_out >> {byte_count_out, 3'b000}) == 64'd0), "result bytes past count not zero")

	// an empty beat needs no keystream and comes straight through as zero
	`CC20_ASSERT_NEXT(a_empty_beat, (in_valid && !in_stall && byte_count == 4'd0) ##1 (!out_valid || !out_stall), out_valid && byte_count_out == 4'd0 && data_out == 64'd0, "empty beat not passed through")

endmodule

bind chacha20_keystream_xor_top cc20_checker u_cc20_checker (.*);

`default_nettype wire

// ----- tb/chacha20_keystream_xor_checker.sv -----
// ----------------------------------------------------------------------------
// chacha20 keystream xor checker
// tracks register writes and input beats, predicts each output beat from its
// own chacha20 block function and compares the beats that come out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chacha20_keystream_xor_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [63:0]                    data_in,
	input  logic [3:0]                     byte_count,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [63:0]                    data_out,
	input  logic [3:0]                     byte_count_out,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);

	import cc20_pkg::*;

	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  count;
	} cipher_beat_t;

	cipher_beat_t     cipher_q [$];
	logic [3:0][63:0] key_words;
	logic [63:0]      nonce_word;
	logic [63:0]      block_ctr;
	logic [511:0]     keystream;
	logic [2:0]       word_pos;
	logic             keystream_valid;
	int               mismatches;
	int               beats_checked;

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// one 64-byte chacha20 block, word 2i in the low half of 64-bit word i
	function automatic logic [511:0] chacha_keystream_block(input logic [255:0] key,
			input logic [63:0] ctr, input logic [63:0] iv);
		logic [31:0]  init [16];
		logic [31:0]  x [16];
		logic [511:0] blk;
		logic [15:0]  sel;
		int           a, b, c, d, i, r, q;
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (i = 0; i < 8; i++)
			init[4 + i] = key[32*i +: 32];
		init[12] = ctr[31:0];
		init[13] = ctr[63:32];
		init[14] = iv[31:0];
		init[15] = iv[63:32];
		for (i = 0; i < 16; i++)
			x[i] = init[i];
		for (r = 0; r < ROUNDS; r++) begin
			for (q = 0; q < 4; q++) begin
				sel = QR_SEL[(r % 2) * 4 + q];
				a = int'(sel[3:0]);
				b = int'(sel[7:4]);
				c = int'(sel[11:8]);
				d = int'(sel[15:12]);
				x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
				x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
				x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
				x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
			end
		end
		for (i = 0; i < 8; i++)
			blk[64*i +: 64] = {x[2*i+1] + init[2*i+1], x[2*i] + init[2*i]};
		return blk;
	endfunction

	task automatic flag(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch after %0d good beats: %s", $time, beats_checked, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		cipher_beat_t want;
		logic [3:0]   n;
		logic [63:0]  mask;
		logic         rewind;
		if (!arst_n) begin
			cipher_q.delete();
			key_words       = '0;
			nonce_word      = '0;
			block_ctr       = '0;
			keystream       = '0;
			word_pos        = '0;
			keystream_valid = 1'b0;
			mismatches      = 0;
			beats_checked   = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					flag($sformatf("unexpected beat data_out %h byte_count_out %0d",
						data_out, byte_count_out));
				end else begin
					want = cipher_q.pop_front();
					if (data_out !== want.text)
						flag($sformatf("data_out expected %h got %h", want.text, data_out));
					if (byte_count_out !== want.count)
						flag($sformatf("byte_count_out expected %0d got %0d",
							want.count, byte_count_out));
					beats_checked++;
				end
			end

			if (cfg_we) begin
				rewind = 1'b0;
				case (cfg_index)
					REG_KEY_LOW, REG_KEY_MID_LOW, REG_KEY_MID_HIGH, REG_KEY_HIGH: begin
						key_words[cfg_index[1:0]] = cfg_data;
						rewind = 1'b1;
					end
					REG_NONCE: begin
						nonce_word = cfg_data;
						rewind = 1'b1;
					end
					default: ;
				endcase
				if (rewind) begin
					block_ctr       = '0;
					word_pos        = '0;
					keystream_valid = 1'b0;
				end
			end

			if (in_valid && !in_stall) begin
				if (byte_count == 4'd0) begin
					cipher_q.push_back('{text: '0, count: '0});
				end else begin
					n = (byte_count > BYTES_PER_BEAT) ? BYTES_PER_BEAT : byte_count;
					mask = {64{1'b1}} >> (64 - 8 * int'(n));
					if (!keystream_valid) begin
						keystream = chacha_keystream_block(key_words, block_ctr, nonce_word);
						block_ctr = block_ctr + 64'd1;
						keystream_valid = 1'b1;
					end
					cipher_q.push_back('{text: (data_in ^ keystream[64*word_pos +: 64]) & mask,
						count: n});
					word_pos = word_pos + 3'd1;
					if (word_pos == 3'd0)
						keystream_valid = 1'b0;
				end
			end

			fail_count <= mismatches;
			pending    <= cipher_q.size();
			checked    <= beats_checked;
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// chacha20 keystream xor testbench
// drives key/nonce settings and data beats into the cipher with random gaps
// and output back-pressure; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import cc20_pkg::*;

	localparam int STALL_PCT      = 15;          // idle share per side, percent
	localparam int SETTLE_CYCLES  = ROUNDS + 20; // covers one block generation
	localparam int WATCHDOG_LIMIT = 2000;        // cycles with no beat moving
	localparam int RANDOM_PHASES  = 8;
	localparam int STEADY_PHASE   = 3;           // this phase runs with no idling

	// write order of the registers, register i has index i
	localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{
		REG_KEY_LOW, REG_KEY_MID_LOW, REG_KEY_MID_HIGH, REG_KEY_HIGH, REG_NONCE
	};

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [63:0]          cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [63:0]          data_in    = '0;
	logic [3:0]           byte_count = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [63:0]          data_out;
	logic [3:0]           byte_count_out;

	logic steady = 1'b0; // both sides stop idling while set

	int fail_count, pending, checked;
	int beats_sent    = 0;
	int short_beats   = 0;
	int empty_beats   = 0;
	int oversize      = 0;
	int cfg_writes    = 0;
	int settings_used = 0;
	int quiet_cycles  = 0;

	chacha20_keystream_xor_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_in        (data_in),
		.byte_count     (byte_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_out       (data_out),
		.byte_count_out (byte_count_out)
	);

	chacha20_keystream_xor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_in        (data_in),
		.byte_count     (byte_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_out       (data_out),
		.byte_count_out (byte_count_out),
		.fail_count     (fail_count),
		.pending        (pending),
		.checked        (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, independent of what the sender does
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
	end

	// watchdog: any beat or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles, %0d beats still owed",
				WATCHDOG_LIMIT, pending);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// key and nonce values lean toward the all-zero and all-one extremes
	function automatic logic [63:0] pick_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// mostly full beats, some short ones, a few zero and oversized counts
	function automatic logic [3:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return BYTES_PER_BEAT;
		if (r < 88)
			return 4'($urandom_range(1, 7));
		if (r < 94)
			return 4'd0;
		return 4'($urandom_range(9, 15));
	endfunction

	// one input beat; valid stays high into the next call, so it only drops
	// when a random gap is taken or the stream is parked
	task automatic send_beat(input logic [63:0] text, input logic [3:0] count);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_in    <= text;
		byte_count <= count;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (count == 4'd0)
			empty_beats++;
		else if (count > BYTES_PER_BEAT)
			oversize++;
		else if (count < BYTES_PER_BEAT)
			short_beats++;
	endtask

	// park the input, let every owed beat drain, then give the block time to
	// finish any block generation still in flight
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// writes the selected registers in index order, then optionally one write
	// to an index past the last register, which must leave everything alone
	task automatic program_regs(input logic [4:0] sel, input logic [5*64-1:0] vals,
			input bit stray);
		int i;
		for (i = 0; i < 5; i++) begin
			if (sel[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= REG_ORDER[i];
				cfg_data  <= vals[64*i +: 64];
				@(posedge clk);
				cfg_writes++;
			end
		end
		if (stray) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_NONCE) + 1,
				(1 << CFG_IDX_W) - 1));
			cfg_data  <= pick_word();
			@(posedge clk);
			cfg_writes++;
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [4:0]       sel;
		logic [5*64-1:0]  vals;
		bit               stray;
		int               phase, n, i;

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting, all-zero key and nonce: zero data shows the raw
		// keystream of block 0, then the count edge cases run into block 1
		for (i = 0; i < 8; i++)
			send_beat('0, BYTES_PER_BEAT);
		send_beat('1, BYTES_PER_BEAT);
		send_beat('1, 4'd1);
		send_beat('1, 4'd0);     // zero count: no keystream used
		send_beat('1, 4'd15);    // saturates to a full beat
		send_beat({$urandom, $urandom}, 4'd9);
		send_beat({$urandom, $urandom}, 4'd7);

		// every register at all ones, the other extreme
		settle();
		program_regs(5'b11111, '1, 1'b0);
		send_beat('1, BYTES_PER_BEAT);
		send_beat({$urandom, $urandom}, 4'd3);
		send_beat('1, 4'd0);
		send_beat('1, 4'd12);

		// only an out-of-range index: position and counter must carry on
		settle();
		program_regs(5'b00000, '0, 1'b1);
		for (i = 0; i < 4; i++)
			send_beat({$urandom, $urandom}, BYTES_PER_BEAT);

		// random settings; writes land mid-block since phases end anywhere
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			steady <= (phase == STEADY_PHASE);
			sel   = 5'($urandom_range(0, 31));
			stray = ($urandom_range(0, 3) == 0);
			vals  = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
			program_regs(sel, vals, stray);
			n = $urandom_range(60, 100);
			for (i = 0; i < n; i++)
				send_beat({$urandom, $urandom}, pick_count());
		end

		settle();

		$display("covered %0d beats (%0d short, %0d zero-length, %0d oversized count)",
			beats_sent, short_beats, empty_beats, oversize);
		$display("%0d results compared across %0d register settings, %0d register writes",
			checked, settings_used, cfg_writes);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d expected beats never came out", fail_count, pending);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- chacha20_keystream_xor_top.f -----
+incdir+design
design/cc20_pkg.sv
design/cc20_qr.sv
design/cc20_core.sv
design/chacha20_keystream_xor_top.sv
design/cc20_checker.sv
tb/chacha20_keystream_xor_checker.sv
tb/tb.sv
